### rtl/ialu_pkg.sv
package ialu_pkg;

   localparam int WORD_W = 32;
   localparam int SHAMT_W = $clog2(WORD_W);

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_SUB  = 5'd1;
   localparam logic [4:0] OP_EQ   = 5'd2;
   localparam logic [4:0] OP_GT   = 5'd3;
   localparam logic [4:0] OP_GTU  = 5'd4;
   localparam logic [4:0] OP_SHL  = 5'd5;
   localparam logic [4:0] OP_SHR  = 5'd6;
   localparam logic [4:0] OP_SHRU = 5'd7;
   localparam logic [4:0] OP_AND  = 5'd8;
   localparam logic [4:0] OP_OR   = 5'd9;
   localparam logic [4:0] OP_XOR  = 5'd10;
   localparam logic [4:0] OP_MIN  = 5'd11;
   localparam logic [4:0] OP_MAX  = 5'd12;
   localparam logic [4:0] OP_MINU = 5'd13;
   localparam logic [4:0] OP_MAXU = 5'd14;
   localparam logic [4:0] OP_SXT8 = 5'd15;
   localparam logic [4:0] OP_SXT16 = 5'd16;
   localparam logic [4:0] OP_NEG  = 5'd17;
   localparam logic [4:0] OP_NOT  = 5'd18;
   localparam logic [4:0] OP_MUL  = 5'd19;
   localparam logic [4:0] OP_DIV  = 5'd20;
   localparam logic [4:0] OP_DIVU = 5'd21;
   localparam logic [4:0] OP_MOD  = 5'd22;
   localparam logic [4:0] OP_MODU = 5'd23;
   localparam logic [4:0] OP_ROTL = 5'd24;
   localparam logic [4:0] OP_ROTR = 5'd25;
   localparam logic [4:0] OP_ABS  = 5'd26;

   typedef struct packed {
      logic [4:0]        kind;
      logic [WORD_W-1:0] operand_a;
      logic [WORD_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic              error_flag;
   } rsp_type;

   typedef struct packed {
      logic is_div;
      logic want_rem;
      logic neg_out;
      logic by_zero;
   } div_ctl_type;

   typedef struct packed {
      logic              valid;
      div_ctl_type       ctl;
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] quo;
      logic [WORD_W-1:0] dsor;
   } div_stage_type;

endpackage

### rtl/ialu_simple.sv
module ialu_simple (
   input  logic                     clock,
   input  logic                     adv,
   input  ialu_pkg::req_type        op,
   output logic [ialu_pkg::WORD_W-1:0] result
);
   import ialu_pkg::*;

   logic [WORD_W-1:0]  a, b;
   logic [WORD_W-1:0]  res_in, res_ff;
   logic [SHAMT_W-1:0] sh;
   logic [SHAMT_W:0]   sh_inv;
   logic               big_shift, sgt, ugt;
   logic [WORD_W-1:0]  neg_a;

   always_comb begin
      a = op.operand_a;
      b = op.operand_b;
      sh = b[SHAMT_W-1:0];
      sh_inv = (SHAMT_W+1)'(WORD_W) - {1'b0, sh};
      big_shift = (b >> SHAMT_W) != '0;
      sgt = $signed(a) > $signed(b);
      ugt = a > b;
      neg_a = '0 - a;
      unique case (op.kind)
         OP_ADD:   res_in = a + b;
         OP_SUB:   res_in = a - b;
         OP_EQ:    res_in = WORD_W'(a == b);
         OP_GT:    res_in = WORD_W'(sgt);
         OP_GTU:   res_in = WORD_W'(ugt);
         OP_SHL:   res_in = big_shift ? '0 : a << sh;
         OP_SHR:   res_in = big_shift ? '0 : WORD_W'($signed(a) >>> sh);
         OP_SHRU:  res_in = big_shift ? '0 : a >> sh;
         OP_AND:   res_in = a & b;
         OP_OR:    res_in = a | b;
         OP_XOR:   res_in = a ^ b;
         OP_MIN:   res_in = sgt ? b : a;
         OP_MAX:   res_in = ($signed(b) > $signed(a)) ? b : a;
         OP_MINU:  res_in = (a < b) ? a : b;
         OP_MAXU:  res_in = ugt ? a : b;
         OP_SXT8:  res_in = {{(WORD_W-8){a[7]}}, a[7:0]};
         OP_SXT16: res_in = {{(WORD_W-16){a[15]}}, a[15:0]};
         OP_NEG:   res_in = neg_a;
         OP_NOT:   res_in = ~a;
         OP_MUL:   res_in = WORD_W'(a * b);
         // a shift by the full width yields zero, so amount zero returns a
         OP_ROTL:  res_in = (a << sh) | (a >> sh_inv);
         OP_ROTR:  res_in = (a >> sh) | (a << sh_inv);
         OP_ABS:   res_in = a[WORD_W-1] ? neg_a : a;
         default:  res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

### rtl/ialu_div.sv
module ialu_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  ialu_pkg::req_type        op,
   output ialu_pkg::div_stage_type  out_stage
);
   import ialu_pkg::*;

   div_stage_type st_ff [0:WORD_W];
   div_stage_type st_in [0:WORD_W];

   logic na, nb, signed_op;

   always_comb begin
      na = op.operand_a[WORD_W-1];
      nb = op.operand_b[WORD_W-1];
      signed_op = (op.kind == OP_DIV) || (op.kind == OP_MOD);
      st_in[0].valid = in_valid;
      st_in[0].ctl.is_div = (op.kind == OP_DIV) || (op.kind == OP_DIVU) ||
                            (op.kind == OP_MOD) || (op.kind == OP_MODU);
      st_in[0].ctl.want_rem = (op.kind == OP_MOD) || (op.kind == OP_MODU);
      st_in[0].ctl.by_zero = op.operand_b == '0;
      st_in[0].ctl.neg_out = (op.kind == OP_DIV) ? (na ^ nb) :
                             (op.kind == OP_MOD) ? na : 1'b0;
      st_in[0].rem = '0;
      st_in[0].quo = (signed_op && na) ? '0 - op.operand_a : op.operand_a;
      st_in[0].dsor = (signed_op && nb) ? '0 - op.operand_b : op.operand_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].valid <= 1'b0;
      end else if (adv) begin
         st_ff[0] <= st_in[0];
      end
   end

   for (genvar k = 1; k <= WORD_W; k++) begin : g_step
      logic [WORD_W:0] trial;
      logic            ge;

      // one restoring step: bring down the next dividend bit
      always_comb begin
         trial = {st_ff[k-1].rem, st_ff[k-1].quo[WORD_W-1]};
         ge = trial >= {1'b0, st_ff[k-1].dsor};
         st_in[k].valid = st_ff[k-1].valid;
         st_in[k].ctl = st_ff[k-1].ctl;
         st_in[k].dsor = st_ff[k-1].dsor;
         st_in[k].rem = ge ? WORD_W'(trial - {1'b0, st_ff[k-1].dsor})
                           : trial[WORD_W-1:0];
         st_in[k].quo = {st_ff[k-1].quo[WORD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (adv) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_stage = st_ff[WORD_W];

endmodule

### rtl/integer_alu_32_top.sv
// 32-bit integer alu, fully pipelined
// req channel: one beat carries kind, operand_a and operand_b; a beat is
// taken when req_valid is high and req_stall is low
// rsp channel: one beat per request, in request order, with result_word and
// error_flag; a beat is taken when rsp_valid is high and rsp_stall is low
// every operation takes the same path length from request beat to response
// beat; the length is set by the divider, which retires one quotient bit
// per pipeline stage, and all other operations are delayed to match so
// order is kept
// throughput: one beat per cycle, divides included, except during a freeze
// a divide or modulo by zero answers 0 with error_flag set
// reset clears all valid bits; the pipeline comes up empty
// when rsp_stall holds a waiting response, the whole pipeline freezes and
// req_stall is raised in the same cycle; nothing is dropped or repeated
module integer_alu_32_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ialu_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ialu_pkg::rsp_type   rsp_payload
);
   import ialu_pkg::*;

   logic              adv;
   logic              v0_ff;
   req_type           op_ff;
   logic [WORD_W-1:0] simple_res;
   logic [WORD_W-1:0] line_ff [1:WORD_W];
   div_stage_type     dout;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [WORD_W-1:0] dval;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         op_ff <= req_payload;
      end
   end

   ialu_simple u_simple (
      .clock  (clock),
      .adv    (adv),
      .op     (op_ff),
      .result (simple_res)
   );

   ialu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v0_ff),
      .op        (op_ff),
      .out_stage (dout)
   );

   // simple results wait alongside the divider stages
   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[1] <= simple_res;
         for (int k = 2; k <= WORD_W; k++) line_ff[k] <= line_ff[k-1];
      end
   end

   always_comb begin
      dval = dout.ctl.want_rem ? dout.rem : dout.quo;
      if (dout.ctl.is_div) begin
         rsp_in.error_flag = dout.ctl.by_zero;
         if (dout.ctl.by_zero) rsp_in.result_word = '0;
         else rsp_in.result_word = dout.ctl.neg_out ? '0 - dval : dval;
      end else begin
         rsp_in.error_flag = 1'b0;
         rsp_in.result_word = line_ff[WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dout.valid;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error_flag |-> rsp_ff.result_word == '0)
      else $error("error beat with nonzero result");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while output held");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");
`endif

endmodule
